[rtl/sbs_pkg.sv]
// Shared types, codes and widths for the segment byte statistics block.
// Depends on nothing; imported by every module of the block.
package sbs_pkg;

    localparam int MAX_SEGMENT = 65536;

    localparam int SEG_W   = 17;
    localparam int CNT_W   = 17;
    localparam int POS_W   = 16;
    localparam int BITS_W  = 20;
    localparam int TREND_W = 18;
    localparam int VAL_W   = 21;
    localparam int ADDR_W  = 8;
    localparam int NIB_N   = 16;

    localparam logic [SEG_W-1:0] SEG_MAX   = SEG_W'(MAX_SEGMENT);
    localparam logic [SEG_W-1:0] SEG_RESET = SEG_W'(4096);

    localparam logic [1:0] FUNC_DATA  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [2:0] TBL_COUNT = 3'd0;
    localparam logic [2:0] TBL_ZONE  = 3'd1;
    localparam logic [2:0] TBL_LOW   = 3'd2;
    localparam logic [2:0] TBL_POS   = 3'd3;
    localparam logic [2:0] TBL_GAP   = 3'd4;
    localparam logic [2:0] TBL_TOTAL = 3'd5;

    localparam logic [7:0] TOT_BITS  = 8'd0;
    localparam logic [7:0] TOT_TREND = 8'd1;
    localparam logic [7:0] TOT_BYTES = 8'd2;

    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_DONE = 2'd1;
    localparam logic [1:0] STS_FULL = 2'd2;
    localparam logic [1:0] STS_BAD  = 2'd3;

    // One per-value entry: count, last position and last gap.
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] gap;
    } entry_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic              clr;
        logic [ADDR_W-1:0] addr;
        entry_t            wdata;
    } ram_req_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    function automatic logic [2:0] nib_ones(input logic [3:0] n);
        logic [2:0] r;
        case (n)
            4'h0: r = 3'd0;
            4'h1, 4'h2, 4'h4, 4'h8: r = 3'd1;
            4'h3, 4'h5, 4'h6, 4'h9, 4'hA, 4'hC: r = 3'd2;
            4'h7, 4'hB, 4'hD, 4'hE: r = 3'd3;
            default: r = 3'd4;
        endcase
        return r;
    endfunction

endpackage

[rtl/sbs_entry_ram.sv]
// Per-value entry memory (count, last position, last gap) with valid bits.
// Depends on sbs_pkg; an entry that is not valid reads as zero.
module sbs_entry_ram
    import sbs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  ram_req_t req,
    output entry_t   rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    entry_t             mem [DEPTH];
    logic [DEPTH-1:0]   vld_reg;
    entry_t             rd_reg;
    logic               rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rd_reg <= mem[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.clr)
            begin
                vld_reg <= '0;
            end
            else if (req.wr_en)
            begin
                vld_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= vld_reg[req.addr];
            end
        end
    end

    assign rdata = rd_vld_reg ? rd_reg : '0;

endmodule

[rtl/segment_byte_statistics_unit.sv]
// Top level of the segment byte statistics block: request sequencer,
// nibble and total counters, result register. Depends on sbs_pkg, sbs_entry_ram.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-------------------------------------------
//  s_*     | in  | s_tvalid / s_tready | s_tdata: byte_value, table_req, index
//          |     |                     | s_tuser: func
//  m_*     | out | m_tvalid / m_tready | m_tdata: value (21b two's complement)
//          |     |                     | m_tuser: status
//  cfg_*   | in  | cfg_we              | cfg_data: bytes per segment
//
// For each request the accept cycle issues the read of the per-value entry memory;
// the execute state then modifies and writes it back (data requests) and loads
// the result register, once that register can take the answer.
// A stalled result holds the block in its execute cycle; a new request is taken
// while a finished result still waits. Reset (and a clear request) empties all
// statistics at once through the entry valid bits; no clearing pass is needed.
module segment_byte_statistics_unit
    import sbs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,   // [7:0] byte_value, [10:8] table_req, [18:11] index
    input  logic [1:0]       s_tuser,   // [1:0] func
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,   // [20:0] value
    output logic [1:0]       m_tuser,   // [1:0] status
    input  logic             cfg_we,
    input  logic [SEG_W-1:0] cfg_data   // bytes per segment
);

    state_t state_reg, state_next;

    // Held request fields.
    logic [1:0]        func_reg;
    logic [7:0]        byte_reg;
    logic [2:0]        tbl_reg;
    logic [7:0]        idx_reg;

    logic [SEG_W-1:0]  seg_size_reg;

    // Small statistics kept in flops.
    logic [CNT_W-1:0]   zone_reg [NIB_N];
    logic [CNT_W-1:0]   low_reg  [NIB_N];
    logic [BITS_W-1:0]  bits_reg;
    logic signed [TREND_W-1:0] trend_reg;
    logic [SEG_W-1:0]   pos_reg;
    logic [7:0]         prev_reg;
    logic               full_reg;

    // Result register.
    logic               m_valid_reg;
    logic [VAL_W-1:0]   value_reg;
    logic [1:0]         status_reg;

    ram_req_t          ram_req;
    entry_t            ent;
    entry_t            ent_new;

    logic              accept;
    logic              out_free;
    logic              fire;
    logic              byte_go;
    logic              clear_go;
    logic [SEG_W-1:0]  eff_size;
    logic [SEG_W-1:0]  pos_inc;
    logic [3:0]        hi;
    logic [3:0]        lo;
    logic [VAL_W-1:0]  rd_value;
    logic [1:0]        rd_status;
    logic [VAL_W-1:0]  res_value;
    logic [1:0]        res_status;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    // Finish the request only when the result register can take its answer.
    assign fire     = (state_reg == ST_EXEC) && out_free;
    assign byte_go  = fire && (func_reg == FUNC_DATA) && !full_reg;
    assign clear_go = fire && (func_reg == FUNC_CLEAR);

    assign hi      = byte_reg[7:4];
    assign lo      = byte_reg[3:0];
    assign pos_inc = pos_reg + 1'b1;

    // Limit the configured size to 1..MAX_SEGMENT.
    always_comb
    begin
        if (seg_size_reg == '0)
        begin
            eff_size = SEG_W'(1);
        end
        else if (seg_size_reg > SEG_MAX)
        begin
            eff_size = SEG_MAX;
        end
        else
        begin
            eff_size = seg_size_reg;
        end
    end

    // Entry memory: read on accept, write back in the execute cycle.
    always_comb
    begin
        ram_req.rd_en = accept;
        ram_req.wr_en = byte_go;
        ram_req.clr   = clear_go;
        if (state_reg == ST_IDLE)
        begin
            ram_req.addr = (s_tuser == FUNC_DATA) ? s_tdata[7:0] : s_tdata[18:11];
        end
        else
        begin
            ram_req.addr = byte_reg;
        end
        ram_req.wdata = ent_new;
    end

    sbs_entry_ram u_entry_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ram_req),
        .rdata (ent)
    );

    // First sighting of a value sets only the position; later ones the gap too.
    always_comb
    begin
        ent_new.cnt = ent.cnt + 1'b1;
        ent_new.pos = pos_reg[POS_W-1:0];
        if (ent.cnt == '0)
        begin
            ent_new.gap = ent.gap;
        end
        else
        begin
            ent_new.gap = pos_reg[POS_W-1:0] - ent.pos;
        end
    end

    // Statistic lookup for read requests.
    always_comb
    begin
        rd_value  = '0;
        rd_status = STS_OK;
        case (tbl_reg)
            TBL_COUNT: rd_value = VAL_W'(ent.cnt);
            TBL_ZONE:
            begin
                if (idx_reg[7:4] != 4'd0)
                begin
                    rd_status = STS_BAD;
                end
                else
                begin
                    rd_value = VAL_W'(zone_reg[idx_reg[3:0]]);
                end
            end
            TBL_LOW:
            begin
                if (idx_reg[7:4] != 4'd0)
                begin
                    rd_status = STS_BAD;
                end
                else
                begin
                    rd_value = VAL_W'(low_reg[idx_reg[3:0]]);
                end
            end
            TBL_POS: rd_value = VAL_W'(ent.pos);
            TBL_GAP: rd_value = VAL_W'(ent.gap);
            TBL_TOTAL:
            begin
                case (idx_reg)
                    TOT_BITS:  rd_value = VAL_W'(bits_reg);
                    TOT_TREND: rd_value = VAL_W'(trend_reg);  // sign-extends
                    TOT_BYTES: rd_value = VAL_W'(pos_reg);
                    default:   rd_status = STS_BAD;
                endcase
            end
            default: rd_status = STS_BAD;
        endcase
    end

    always_comb
    begin
        res_value  = '0;
        res_status = STS_OK;
        case (func_reg)
            FUNC_DATA:
            begin
                if (full_reg)
                begin
                    res_status = STS_FULL;
                end
                else if (pos_inc >= eff_size)
                begin
                    res_status = STS_DONE;
                end
            end
            FUNC_READ:
            begin
                res_value  = rd_value;
                res_status = rd_status;
            end
            default:
            begin
                res_value  = '0;
                res_status = STS_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_EXEC;
            ST_EXEC: if (fire)   state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold request fields for the execute cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= s_tuser;
            byte_reg <= s_tdata[7:0];
            tbl_reg  <= s_tdata[10:8];
            idx_reg  <= s_tdata[18:11];
        end
        if (fire)
        begin
            value_reg  <= res_value;
            status_reg <= res_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            seg_size_reg <= SEG_RESET;
            m_valid_reg  <= 1'b0;
            bits_reg     <= '0;
            trend_reg    <= '0;
            pos_reg      <= '0;
            prev_reg     <= '0;
            full_reg     <= 1'b0;
            for (int i = 0; i < NIB_N; i++)
            begin
                zone_reg[i] <= '0;
                low_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                seg_size_reg <= cfg_data;
            end

            if (fire)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            if (clear_go)
            begin
                bits_reg  <= '0;
                trend_reg <= '0;
                pos_reg   <= '0;
                prev_reg  <= '0;
                full_reg  <= 1'b0;
                for (int i = 0; i < NIB_N; i++)
                begin
                    zone_reg[i] <= '0;
                    low_reg[i]  <= '0;
                end
            end
            else if (byte_go)
            begin
                zone_reg[hi] <= zone_reg[hi] + 1'b1;
                low_reg[lo]  <= low_reg[lo] + 1'b1;
                bits_reg     <= bits_reg + BITS_W'(nib_ones(hi)) + BITS_W'(nib_ones(lo));
                // Trend counts only from the second byte of the segment on.
                if (pos_reg != '0)
                begin
                    if (prev_reg > byte_reg)
                    begin
                        trend_reg <= trend_reg + TREND_W'(1);
                    end
                    else if (prev_reg < byte_reg)
                    begin
                        trend_reg <= trend_reg - TREND_W'(1);
                    end
                end
                prev_reg <= byte_reg;
                pos_reg  <= pos_inc;
                if (pos_inc >= eff_size)
                begin
                    full_reg <= 1'b1;
                end
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, value_reg};
    assign m_tuser  = status_reg;

endmodule

[rtl/sbs_checker.sv]
// Port-level checks for the segment byte statistics block, bound to the top.
// Depends on sbs_pkg for status codes.
module sbs_checker
    import sbs_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [23:0]      m_tdata,
    input logic [1:0]       m_tuser
);

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Any non-ok status carries a zero value.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != STS_OK) |-> m_tdata == 24'd0)
        else $error("non-ok status with nonzero value");

    // One request at a time: ready drops after an accept.
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

endmodule

bind segment_byte_statistics_unit sbs_checker u_sbs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
